// ----- rtl/core/plu_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the unit converter
package plu_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int VALUE_W    = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CNT_W      = $clog2(MAX_ROWS + 1);
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int SUM_W      = VALUE_W + 4;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int IN_BITS    = ROW_W + 4 * VALUE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_P2E   = 2'd1,
        CMD_E2P   = 2'd2
    } t_in_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_INTERP = 3'd0,
        ST_EXTRAP = 3'd1,
        ST_PASS   = 3'd2,
        ST_ZERO   = 3'd3,
        ST_SAT    = 3'd4
    } t_conv_st;

    typedef enum logic [0:0] {
        CFG_ROWS   = 1'b0,
        CFG_ENABLE = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_ONE,
        RD_LAST,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW0,
        S_ROWL,
        S_BELOW,
        S_ABOVE,
        S_SCAN,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    wr;
        t_rd_sel rd_sel;
        logic    lat_a;
        logic    lat_b;
        logic    k_init;
        logic    k_inc;
        logic    seg_set;
        logic    seg_extrap;
        logic    x0_b;
        logic    diff;
        logic    mul;
        logic    zero_dx;
        logic    div_step;
        logic    add;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic enabled;
        logic below;
        logic above;
        logic hit;
        logic dx_zero;
        logic div_last;
    } t_dp_sts;

endpackage

// ----- rtl/core/plu_ctrl.sv -----
// sequencing state machine: table search, multiply, divide and output hand-off
module plu_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [plu_pkg::CMD_W-1:0]  i_in_cmd,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output plu_pkg::t_dp_cmd           o_dp_cmd,
    input  plu_pkg::t_dp_sts           i_dp_sts
);
    import plu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   is_conv;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign is_conv     = (i_in_cmd == CMD_P2E) || (i_in_cmd == CMD_E2P);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_conv) begin
                    n_state = i_dp_sts.enabled ? S_ROW0 : S_OUT;
                end
            end
            S_ROW0:  n_state = S_ROWL;
            S_ROWL: begin
                if (i_dp_sts.below) begin
                    n_state = S_BELOW;
                end else if (i_dp_sts.above) begin
                    n_state = S_ABOVE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_BELOW: n_state = S_DIFF;
            S_ABOVE: n_state = S_DIFF;
            S_SCAN: begin
                if (i_dp_sts.hit) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = i_dp_sts.dx_zero ? S_OUT : S_DIV;
            S_DIV: begin
                if (i_dp_sts.div_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd        = '0;
        o_dp_cmd.rd_sel = RD_ZERO;
        case (r_state)
            S_IDLE: begin
                o_dp_cmd.wr   = accept && (i_in_cmd == CMD_WRITE);
                o_dp_cmd.load = accept && is_conv;
            end
            S_ROW0: begin
                o_dp_cmd.lat_a  = 1'b1;
                o_dp_cmd.rd_sel = RD_LAST;
            end
            S_ROWL: begin
                o_dp_cmd.lat_b = 1'b1;
                if (i_dp_sts.below) begin
                    o_dp_cmd.rd_sel = RD_ONE;
                end else if (i_dp_sts.above) begin
                    o_dp_cmd.rd_sel = RD_PREV;
                end else begin
                    o_dp_cmd.rd_sel = RD_ONE;
                    o_dp_cmd.k_init = 1'b1;
                end
            end
            S_BELOW: begin
                o_dp_cmd.lat_b      = 1'b1;
                o_dp_cmd.seg_set    = 1'b1;
                o_dp_cmd.seg_extrap = 1'b1;
            end
            S_ABOVE: begin
                o_dp_cmd.lat_a      = 1'b1;
                o_dp_cmd.seg_set    = 1'b1;
                o_dp_cmd.seg_extrap = 1'b1;
                o_dp_cmd.x0_b       = 1'b1;
            end
            S_SCAN: begin
                if (i_dp_sts.hit) begin
                    o_dp_cmd.lat_b   = 1'b1;
                    o_dp_cmd.seg_set = 1'b1;
                end else begin
                    o_dp_cmd.lat_a  = 1'b1;
                    o_dp_cmd.k_inc  = 1'b1;
                    o_dp_cmd.rd_sel = RD_NEXT;
                end
            end
            S_DIFF: o_dp_cmd.diff = 1'b1;
            S_MUL: begin
                o_dp_cmd.zero_dx = i_dp_sts.dx_zero;
                o_dp_cmd.mul     = !i_dp_sts.dx_zero;
            end
            S_DIV:  o_dp_cmd.div_step = 1'b1;
            S_ADD:  o_dp_cmd.add      = 1'b1;
            S_OUT:  o_dp_cmd.out_load = out_free;
            default: o_dp_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/core/plu_datapath.sv -----
// breakpoint tables, config registers, segment arithmetic and output word register
module plu_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plu_pkg::t_dp_cmd                    i_cmd,
    output plu_pkg::t_dp_sts                    o_sts,
    input  logic [plu_pkg::CMD_W-1:0]           i_in_cmd,
    input  logic [plu_pkg::ROW_W-1:0]           i_row_index,
    input  logic signed [plu_pkg::VALUE_W-1:0]  i_eng_entry,
    input  logic signed [plu_pkg::VALUE_W-1:0]  i_phys_entry,
    input  logic signed [plu_pkg::VALUE_W-1:0]  i_x_value,
    input  logic signed [plu_pkg::VALUE_W-1:0]  i_noise_offset,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [plu_pkg::CNT_W-1:0]           i_cfg_data,
    output logic signed [plu_pkg::VALUE_W-1:0]  o_result_value,
    output logic [plu_pkg::STAT_W-1:0]          o_conv_status
);
    import plu_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // {a < b, |a - b|}
    function automatic logic [VALUE_W:0] diff_mag(input logic signed [VALUE_W-1:0] a,
                                                  input logic signed [VALUE_W-1:0] b);
        logic signed [VALUE_W:0] d;
        logic [VALUE_W:0]        m;
        d = (VALUE_W+1)'(a) - (VALUE_W+1)'(b);
        m = d[VALUE_W] ? (VALUE_W+1)'(-d) : d;
        return {d[VALUE_W], m[VALUE_W-1:0]};
    endfunction

    // {saturated, clamped value}
    function automatic logic [VALUE_W:0] sat_val(input logic signed [SUM_W-1:0] s);
        logic [VALUE_W:0] r;
        if (s > SUM_MAX) begin
            r = {1'b1, V_MAX};
        end else if (s < SUM_MIN) begin
            r = {1'b1, V_MIN};
        end else begin
            r = {1'b0, s[VALUE_W-1:0]};
        end
        return r;
    endfunction

    logic signed [VALUE_W-1:0] eng_mem  [MAX_ROWS];
    logic signed [VALUE_W-1:0] phys_mem [MAX_ROWS];

    logic [CNT_W-1:0]          r_rows;
    logic                      r_enable;
    logic signed [VALUE_W-1:0] r_x;
    logic signed [VALUE_W-1:0] r_noise;
    logic                      r_x_phys;
    logic [ROW_W-1:0]          r_last;
    logic [ROW_W-1:0]          r_k;
    logic signed [VALUE_W-1:0] r_rd_eng;
    logic signed [VALUE_W-1:0] r_rd_phys;
    logic signed [VALUE_W-1:0] r_xa;
    logic signed [VALUE_W-1:0] r_ya;
    logic signed [VALUE_W-1:0] r_xb;
    logic signed [VALUE_W-1:0] r_yb;
    logic                      r_x0_b;
    t_conv_st                  r_st;
    logic                      r_un;
    logic [VALUE_W-1:0]        r_um;
    logic                      r_dxn;
    logic [VALUE_W-1:0]        r_dxm;
    logic                      r_dyn;
    logic [VALUE_W-1:0]        r_dym;
    logic signed [VALUE_W-1:0] r_y0;
    logic [PROD_W-1:0]         r_quo;
    logic [VALUE_W-1:0]        r_rem;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic signed [VALUE_W-1:0] r_y1;
    logic                      r_sat1;
    logic signed [VALUE_W-1:0] r_out_value;
    t_conv_st                  r_out_status;

    logic [ROW_W-1:0]          rd_addr;
    logic signed [VALUE_W-1:0] rd_x;
    logic signed [VALUE_W-1:0] rd_y;
    logic signed [VALUE_W-1:0] x0;
    logic signed [VALUE_W-1:0] y0;
    logic [PROD_W-1:0]         prod;
    logic [VALUE_W:0]          trial;
    logic                      trial_ge;
    logic [VALUE_W:0]          trial_sub;
    logic                      q_neg;
    logic [VALUE_W+1:0]        q_clamp;
    logic signed [SUM_W-1:0]   q_ext;
    logic signed [SUM_W-1:0]   y1_sum;
    logic [VALUE_W:0]          y1_sat;
    logic signed [SUM_W-1:0]   fin_sum;
    logic [VALUE_W:0]          fin_sat;
    t_conv_st                  fin_st;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = ROW_W'(1);
            RD_LAST: rd_addr = r_last;
            RD_PREV: rd_addr = r_last - ROW_W'(1);
            RD_NEXT: rd_addr = r_k + ROW_W'(1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (CNT_W'(i_row_index) < CNT_W'(MAX_ROWS))) begin
            eng_mem[i_row_index]  <= i_eng_entry;
            phys_mem[i_row_index] <= i_phys_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_eng  <= eng_mem[rd_addr];
        r_rd_phys <= phys_mem[rd_addr];
    end

    assign rd_x = r_x_phys ? r_rd_phys : r_rd_eng;
    assign rd_y = r_x_phys ? r_rd_eng : r_rd_phys;

    assign o_sts.enabled  = r_enable;
    assign o_sts.below    = r_x < r_xa;
    assign o_sts.above    = !(r_x < r_xa) && (r_x >= rd_x);
    assign o_sts.hit      = (r_x < rd_x) || (r_k == r_last);
    assign o_sts.dx_zero  = (r_dxm == '0);
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(PROD_W - 1));

    assign x0 = r_x0_b ? r_xb : r_xa;
    assign y0 = r_x0_b ? r_yb : r_ya;

    assign prod = PROD_W'(r_um) * PROD_W'(r_dym);

    // one quotient bit per cycle, restoring
    assign trial     = {r_rem, r_quo[PROD_W-1]};
    assign trial_ge  = trial >= {1'b0, r_dxm};
    assign trial_sub = trial - {1'b0, r_dxm};

    // any quotient this large saturates, so it is capped before the add
    assign q_neg   = r_un ^ r_dyn ^ r_dxn;
    assign q_clamp = (|r_quo[PROD_W-1:VALUE_W+1]) ? {1'b1, {(VALUE_W+1){1'b0}}}
                                                  : {1'b0, r_quo[VALUE_W:0]};
    assign q_ext   = q_neg ? -SUM_W'(q_clamp) : SUM_W'(q_clamp);
    assign y1_sum  = SUM_W'(r_y0) + q_ext;
    assign y1_sat  = sat_val(y1_sum);

    assign fin_sum = SUM_W'(r_y1) + SUM_W'(r_noise);
    assign fin_sat = sat_val(fin_sum);

    always_comb begin
        if (r_st == ST_ZERO) begin
            fin_st = ST_ZERO;
        end else if (r_sat1 || fin_sat[VALUE_W]) begin
            fin_st = ST_SAT;
        end else begin
            fin_st = r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= CNT_W'(2);
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ROWS:   r_rows   <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default:    r_rows   <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_x_value;
            r_noise  <= i_noise_offset;
            r_x_phys <= (i_in_cmd == CMD_P2E);
            r_y1     <= i_x_value;
            r_sat1   <= 1'b0;
            r_st     <= ST_PASS;
            if (r_rows < CNT_W'(2)) begin
                r_last <= ROW_W'(1);
            end else if (r_rows > CNT_W'(MAX_ROWS)) begin
                r_last <= ROW_W'(MAX_ROWS - 1);
            end else begin
                r_last <= ROW_W'(r_rows - CNT_W'(1));
            end
        end
        if (i_cmd.lat_a) begin
            r_xa <= rd_x;
            r_ya <= rd_y;
        end
        if (i_cmd.lat_b) begin
            r_xb <= rd_x;
            r_yb <= rd_y;
        end
        if (i_cmd.k_init) begin
            r_k <= ROW_W'(1);
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + ROW_W'(1);
        end
        if (i_cmd.seg_set) begin
            r_x0_b <= i_cmd.x0_b;
            r_st   <= i_cmd.seg_extrap ? ST_EXTRAP : ST_INTERP;
        end
        if (i_cmd.diff) begin
            {r_un, r_um}   <= diff_mag(r_x, x0);
            {r_dyn, r_dym} <= diff_mag(r_yb, r_ya);
            {r_dxn, r_dxm} <= diff_mag(r_xb, r_xa);
            r_y0           <= y0;
        end
        if (i_cmd.mul) begin
            r_quo <= prod;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.zero_dx) begin
            r_y1   <= r_y0;
            r_sat1 <= 1'b0;
            r_st   <= ST_ZERO;
        end else if (i_cmd.add) begin
            r_y1   <= y1_sat[VALUE_W-1:0];
            r_sat1 <= y1_sat[VALUE_W];
        end
        if (i_cmd.out_load) begin
            r_out_value  <= fin_sat[VALUE_W-1:0];
            r_out_status <= fin_st;
        end
    end

    assign o_result_value = r_out_value;
    assign o_conv_status  = r_out_status;

endmodule

// ----- rtl/core/piecewise_linear_unit_converter.sv -----
// top level of the piecewise-linear unit converter: ports, field unpacking, controller and datapath
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: cmd; tdata: row, eng, phys, x, noise
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: conv_status; tdata: result_value
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data (always ready)
//
//  one word at a time; table writes and ignored commands complete on acceptance, passthrough goes straight to S_OUT
//  table conversion reads the end rows, searches for the segment, then multiplies and divides:
//  the segment search scans the rows one by one, and the bit-serial divider forms the quotient
//  the output register frees the input side while a result waits on m_axis_tready
//  reset clears control and config only; table rows read undefined until written
module piecewise_linear_unit_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] row_index, [37:6] eng_entry, [69:38] phys_entry,
    // [101:70] x_value, [133:102] noise_offset, upper bits zero
    input  logic [plu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic [plu_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_value
    output logic [plu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // conv_status
    output logic [plu_pkg::STAT_W-1:0]         m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [plu_pkg::CNT_W-1:0]          i_cfg_data
);
    import plu_pkg::*;

    t_dp_cmd                   dp_cmd;
    t_dp_sts                   dp_sts;
    logic [ROW_W-1:0]          row_index;
    logic signed [VALUE_W-1:0] eng_entry;
    logic signed [VALUE_W-1:0] phys_entry;
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] noise_offset;
    logic signed [VALUE_W-1:0] result_value;
    logic [VALUE_W-1:0]        result_bits;

    assign row_index    = s_axis_tdata[ROW_W-1:0];
    assign eng_entry    = $signed(s_axis_tdata[ROW_W +: VALUE_W]);
    assign phys_entry   = $signed(s_axis_tdata[ROW_W + VALUE_W +: VALUE_W]);
    assign x_value      = $signed(s_axis_tdata[ROW_W + 2*VALUE_W +: VALUE_W]);
    assign noise_offset = $signed(s_axis_tdata[ROW_W + 3*VALUE_W +: VALUE_W]);

    assign o_cfg_ready  = 1'b1;
    assign result_bits  = result_value;
    assign m_axis_tdata = OUT_DATA_W'(result_bits);

    plu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_cmd    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    plu_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_in_cmd       (s_axis_tuser),
        .i_row_index    (row_index),
        .i_eng_entry    (eng_entry),
        .i_phys_entry   (phys_entry),
        .i_x_value      (x_value),
        .i_noise_offset (noise_offset),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_value (result_value),
        .o_conv_status  (m_axis_tuser)
    );

endmodule
